// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg - shared types and codes of the sorted priority queue
// Request action codes, result status codes and the stored entry layout.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int PRIO_W = 32;
	localparam int OCC_W  = 5;

	// request action codes
	localparam logic ACT_INSERT  = 1'b0;
	localparam logic ACT_EXTRACT = 1'b1;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// one stored entry
	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

endpackage

// ===== sv/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Sequence: an extract passes S_EXT_RD, S_EXT_OUT and S_FIN; an extract on empty or an
// insert on full goes straight to S_FIN. An insert reads each entry in S_INS_RD and
// writes it one slot back in S_INS_CMP for each of k entries (at most CAPACITY - 1),
// and writes the new entry in S_INS_CMP, or in S_INS_RD when it lands at the front; then S_FIN.
// Flow: one request at a time, in_ready returns with the result.
// Reset: arst_n empties the queue and drops any pending result; memory not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue - bounded max-priority queue
// Entries live in a circular memory in descending priority order. An insert
// walks back from the tail, moving lower-priority entries one slot back,
// until it finds its place; an extract pops the head.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic signed [spq_pkg::DATA_W-1:0]   item_data,
	input  logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [spq_pkg::DATA_W-1:0]   out_data,
	output logic [1:0]                          status,
	output logic [spq_pkg::OCC_W-1:0]           occupancy
);
	import spq_pkg::*;

	localparam int PTR_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_EXT_RD,
		S_EXT_OUT,
		S_FIN
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          left_q;
	logic [PTR_W-1:0]          head_q;
	logic [PTR_W-1:0]          tail_q;
	logic [PTR_W-1:0]          wptr_q;
	logic [PTR_W-1:0]          rptr_q;
	logic signed [DATA_W-1:0]  data_q;
	logic signed [PRIO_W-1:0]  prio_q;
	logic signed [DATA_W-1:0]  res_data_q;
	logic [1:0]                res_status_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  out_data_q;
	logic [1:0]                status_q;
	logic [OCC_W-1:0]          occ_q;

	entry_t                    mem [CAPACITY];
	entry_t                    rd_q;
	logic                      mem_we;
	logic                      mem_re;
	logic [PTR_W-1:0]          mem_waddr;
	logic [PTR_W-1:0]          mem_raddr;
	entry_t                    mem_wdata;
	entry_t                    new_entry;
	logic                      stop_here;
	logic                      accept;
	logic                      out_free;
	logic [CNT_W+OCC_W-1:0]    count_ext;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		ptr_dec = (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
	endfunction

	// handshake
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// shared compare: stored entry keeps its place if its priority is not lower
	assign new_entry.data = data_q;
	assign new_entry.prio = prio_q;
	assign stop_here      = (rd_q.prio >= prio_q);

	// memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = rptr_q;
		mem_waddr = wptr_q;
		mem_wdata = new_entry;
		unique case (state_q)
			S_INS_RD: begin
				if (left_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_INS_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = stop_here ? new_entry : rd_q;
			end
			S_EXT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = head_q;
			end
			default: begin
			end
		endcase
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	assign count_ext = {{OCC_W{1'b0}}, count_q};

	// sequencer, queue pointers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			left_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			wptr_q       <= '0;
			rptr_q       <= '0;
			data_q       <= '0;
			prio_q       <= '0;
			res_status_q <= ST_DONE;
			res_data_q   <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			status_q     <= ST_DONE;
			occ_q        <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						data_q       <= item_data;
						prio_q       <= item_priority;
						res_data_q   <= '0;
						res_status_q <= ST_DONE;
						if (action == ACT_INSERT) begin
							if (count_q == CNT_W'(CAPACITY)) begin
								res_status_q <= ST_FULL;
								state_q      <= S_FIN;
							end else begin
								left_q  <= count_q;
								wptr_q  <= tail_q;
								rptr_q  <= ptr_dec(tail_q);
								state_q <= S_INS_RD;
							end
						end else begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_EXT_RD;
							end
						end
					end
				end
				S_INS_RD: begin
					if (left_q == '0) begin
						count_q <= count_q + 1'b1;
						tail_q  <= ptr_inc(tail_q);
						state_q <= S_FIN;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (stop_here) begin
						count_q <= count_q + 1'b1;
						tail_q  <= ptr_inc(tail_q);
						state_q <= S_FIN;
					end else begin
						wptr_q  <= rptr_q;
						rptr_q  <= ptr_dec(rptr_q);
						left_q  <= left_q - 1'b1;
						state_q <= S_INS_RD;
					end
				end
				S_EXT_RD: begin
					state_q <= S_EXT_OUT;
				end
				S_EXT_OUT: begin
					res_data_q <= rd_q.data;
					head_q     <= ptr_inc(head_q);
					count_q    <= count_q - 1'b1;
					state_q    <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_data_q;
						status_q    <= res_status_q;
						occ_q       <= count_ext[OCC_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign status    = status_q;
	assign occupancy = occ_q;

endmodule

// ===== sv/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker - port-level checks for the sorted priority queue
// Watches the request and result channels and flags illegal results.
// ----------------------------------------------------------------------------
module spq_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [spq_pkg::DATA_W-1:0]   out_data,
	input  logic [1:0]                          status,
	input  logic [spq_pkg::OCC_W-1:0]           occupancy
);
	import spq_pkg::*;

	// only defined status codes show up
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DONE || status == ST_EMPTY || status == ST_FULL))
		else $error("undefined status code");

	// an empty extract leaves nothing stored and returns no data
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (occupancy == '0 && out_data == '0))
		else $error("empty extract with data or occupancy");

	// a dropped insert returns no data
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (out_data == '0))
		else $error("dropped insert with data");

	// one request at a time: the input is closed once a request is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while busy");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn before taken");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.status    (status),
	.occupancy (occupancy)
);

// ===== tb/sv/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue - self-checking bench for the sorted priority queue
// Sends insert and extract requests with random idle gaps on the request side
// and random stalls on the result side. A shadow queue predicts every result;
// each result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

	import spq_pkg::*;

	localparam int QUEUE_DEPTH  = 16;
	localparam int MAX_GAP      = 12;
	localparam int SETTLE_TIME  = 48;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PRINT_LIMIT  = 40;

	typedef struct {
		logic signed [DATA_W-1:0] data;
		logic [1:0]               status;
		logic [OCC_W-1:0]         occ;
	} queue_outcome_t;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     action = ACT_INSERT;
	logic signed [DATA_W-1:0] item_data = '0;
	logic signed [PRIO_W-1:0] item_priority = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] out_data;
	logic [1:0]               status;
	logic [OCC_W-1:0]         occupancy;

	// shadow copy of the stored entries, front is the next to leave
	logic signed [DATA_W-1:0] shadow_data[$];
	logic signed [PRIO_W-1:0] shadow_prio[$];
	queue_outcome_t           outcomes_due[$];

	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;

	sorted_priority_queue #(
		.CAPACITY(QUEUE_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.item_data    (item_data),
		.item_priority(item_priority),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.status       (status),
		.occupancy    (occupancy)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: run limit reached with %0d results outstanding",
				$time, outcomes_due.size());
			$display("FAIL sorted_priority_queue");
			$finish;
		end
	end

	// apply one accepted request to the shadow queue and record its outcome
	function automatic void predict_queue_op(input logic act,
		input logic signed [DATA_W-1:0] d, input logic signed [PRIO_W-1:0] p);
		queue_outcome_t res;
		int             pos;
		res.data   = '0;
		res.status = ST_DONE;
		if (act == ACT_INSERT) begin
			if (shadow_prio.size() >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				// new entry goes behind all of equal or higher priority
				pos = 0;
				while (pos < shadow_prio.size() && shadow_prio[pos] >= p)
					pos++;
				shadow_prio.insert(pos, p);
				shadow_data.insert(pos, d);
			end
		end else begin
			if (shadow_prio.size() == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.data = shadow_data.pop_front();
				void'(shadow_prio.pop_front());
			end
		end
		res.occ = OCC_W'(shadow_prio.size());
		outcomes_due.push_back(res);
	endfunction

	function automatic void note_mismatch(input string what, input longint want,
		input longint got);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("%0t ns: %s mismatch: expected %0d actual %0d",
				$time, what, want, got);
	endfunction

	// compare one accepted result with the oldest prediction
	function automatic void check_result();
		queue_outcome_t want;
		if (outcomes_due.size() == 0) begin
			fail_count++;
			if (fail_count <= PRINT_LIMIT)
				$display("%0t ns: unexpected result: expected none actual data %0d",
					$time, out_data);
		end else begin
			want = outcomes_due.pop_front();
			if (out_data !== want.data)
				note_mismatch("out_data", longint'(want.data), longint'(out_data));
			if (status !== want.status)
				note_mismatch("status", longint'(want.status), longint'(status));
			if (occupancy !== want.occ)
				note_mismatch("occupancy", longint'(want.occ), longint'(occupancy));
		end
	endfunction

	// send one request, idling a random number of cycles first
	task automatic send_request(input logic act, input logic signed [DATA_W-1:0] d,
		input logic signed [PRIO_W-1:0] p);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		item_data     <= d;
		item_priority <= p;
		do @(posedge clk); while (!in_ready);
		predict_queue_op(act, d, p);
	endtask

	// hold off requests until every predicted result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (outcomes_due.size() != 0) @(posedge clk);
	endtask

	// priorities favor a narrow band so that ties are common
	function automatic logic signed [PRIO_W-1:0] pick_priority();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return $signed(PRIO_W'($urandom_range(0, 6))) - 3;
		if (sel < 6) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh8000_0001;
				default: return 32'sh7fff_fffe;
			endcase
		end
		return $urandom;
	endfunction

	// extracts on an empty queue, fields at their extremes, order of service
	task automatic test_field_extremes();
		tx_calm = 1'b0;
		send_request(ACT_EXTRACT, 32'sh7fff_ffff, 32'sh8000_0000);
		send_request(ACT_EXTRACT, -32'sd1, -32'sd1);
		send_request(ACT_INSERT, 32'sh8000_0000, 32'sh8000_0000);
		send_request(ACT_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_request(ACT_INSERT, 32'sd0, 32'sd0);
		send_request(ACT_INSERT, -32'sd1, -32'sd1);
		send_request(ACT_INSERT, 32'sd1, 32'sd0);
		send_request(ACT_INSERT, 32'sd2, 32'sh7fff_ffff);
		repeat (6) send_request(ACT_EXTRACT, 32'sd0, 32'sd0);
		send_request(ACT_EXTRACT, 32'sh5555_aaaa, 32'sh2222_dddd);
	endtask

	// equal priorities leave in arrival order
	task automatic test_equal_priority();
		tx_calm = 1'b1;
		for (int i = 0; i < 4; i++)
			send_request(ACT_INSERT, 32'sd10 + i, 32'sd5);
		send_request(ACT_INSERT, 32'sd20, 32'sd6);
		tx_calm = 1'b0;
		repeat (5) send_request(ACT_EXTRACT, 32'sd0, 32'sd0);
	endtask

	// fill to capacity, overflow, then drain past empty
	task automatic test_fill_overflow();
		wait_for_results();
		tx_calm = 1'b1;
		repeat (QUEUE_DEPTH + 3) send_request(ACT_INSERT, $urandom, pick_priority());
		tx_calm = 1'b0;
		repeat (QUEUE_DEPTH + 2) send_request(ACT_EXTRACT, $urandom, $urandom);
		wait_for_results();
	endtask

	// segments biased toward filling, draining or mixed traffic
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned   seg_left;
		int unsigned   insert_pct;
		traffic_mode_t mode;
		logic          act;
		seg_left = 0;
		for (int unsigned n = 0; n < n_items; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(30, 120);
				mode = traffic_mode_t'($urandom_range(0, 2));
				case (mode)
					MODE_FILL: insert_pct = 85;
					MODE_DRAIN: insert_pct = 15;
					default: insert_pct = 50;
				endcase
				tx_calm = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 7) == 0)
					wait_for_results();
			end
			act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_EXTRACT;
			send_request(act, $urandom, pick_priority());
			seg_left--;
		end
	endtask

	// result side: random stalls, quiet stretches now and then
	initial begin
		int unsigned stall;
		int unsigned rx_count;
		rx_count = 0;
		wait (arst_n);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_result();
			rx_count++;
			if (rx_count % 64 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
		end
	end

	// test sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_equal_priority();
		test_fill_overflow();
		test_random_traffic(1900);
		wait_for_results();
		repeat (SETTLE_TIME) @(posedge clk);
		if (fail_count == 0 && outcomes_due.size() == 0)
			$display("PASS sorted_priority_queue");
		else
			$display("FAIL sorted_priority_queue");
		$finish;
	end

endmodule

// ===== files.f =====
sv/spq_pkg.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
tb/sv/tb_sorted_priority_queue.sv
